@@ sv/asp_pkg.sv @@
// ============================================================================
// asp_pkg
// Shared types, constants and reset values of the accelerometer step peak
// detector: event and trend codes, configuration indexes, queue defaults.
// ============================================================================
package asp_pkg;

  // Field widths
  localparam int unsigned AccelW = 16;
  localparam int unsigned MagW   = 32;
  localparam int unsigned StepW  = 16;
  localparam int unsigned RunW   = 8;
  localparam int unsigned BoundW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Default depth of the queue between front and back (power of two, >= 2)
  localparam int unsigned QueueDepth = 4;

  // Configuration register indexes
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MAG_MIN  = 2'd0;
  localparam cfg_idx_t CFG_MAG_MAX  = 2'd1;
  localparam cfg_idx_t CFG_RISE_RUN = 2'd2;

  // Register reset values
  localparam logic [BoundW-1:0] MagMinReset  = 16'd20;
  localparam logic [BoundW-1:0] MagMaxReset  = 16'd50;
  localparam logic [RunW-1:0]   RiseRunReset = 8'd2;
  localparam logic [MagW-1:0]   MagMinSqReset = 32'(MagMinReset * MagMinReset);
  localparam logic [MagW-1:0]   MagMaxSqReset = 32'(MagMaxReset * MagMaxReset);

  // Saturation limits
  localparam logic [RunW-1:0]  RunMax  = '1;
  localparam logic [StepW-1:0] StepMax = '1;

  // Result event codes
  typedef enum logic [1:0] {
    WAVE_NONE   = 2'd0,
    WAVE_PEAK   = 2'd1,
    WAVE_VALLEY = 2'd2
  } wave_e;

  // Direction of the magnitude trace
  typedef enum logic [1:0] {
    TREND_NONE = 2'd0,
    TREND_RISE = 2'd1,
    TREND_FALL = 2'd2
  } trend_e;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ sv/asp_if.sv @@
// ============================================================================
// asp_sample_if / asp_result_if
// Valid/ready channels: one accelerometer sample in, one detection result out.
// ============================================================================
interface asp_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [asp_pkg::AccelW-1:0]    accel_x;
  logic signed [asp_pkg::AccelW-1:0]    accel_y;
  logic signed [asp_pkg::AccelW-1:0]    accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

interface asp_result_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   wave_event;
  logic [asp_pkg::StepW-1:0]    step_total;
  logic [asp_pkg::MagW-1:0]     magnitude_sq;

  modport source (output valid, output wave_event, output step_total,
                  output magnitude_sq, input ready);
  modport sink   (input valid, input wave_event, input step_total,
                  input magnitude_sq, output ready);
endinterface

@@ sv/asp_front.sv @@
// ============================================================================
// asp_front
// Accepts samples, squares each axis into a register stage, then sums the
// squares and pushes the magnitude into the queue.
// ============================================================================
module asp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  asp_sample_if.sink                sample_i,
  input  asp_pkg::q_status_t        q_status_i,
  output logic                      push_o,
  output logic [asp_pkg::MagW-1:0]  push_mag_o
);

  logic                      s1_valid_q;
  logic [asp_pkg::MagW-1:0]  sq_x_q, sq_y_q, sq_z_q;
  logic [asp_pkg::AccelW-1:0] abs_x, abs_y, abs_z;
  logic                      take;

  // Absolute value; 0x8000 maps onto itself, which is the right magnitude
  function automatic logic [asp_pkg::AccelW-1:0] abs_of(
      input logic [asp_pkg::AccelW-1:0] v);
    abs_of = v[asp_pkg::AccelW-1] ? (~v + 1'b1) : v;
  endfunction

  assign abs_x = abs_of(sample_i.accel_x);
  assign abs_y = abs_of(sample_i.accel_y);
  assign abs_z = abs_of(sample_i.accel_z);

  // Stage drains into the queue whenever there is room
  assign push_o         = s1_valid_q && !q_status_i.full;
  assign sample_i.ready = !s1_valid_q || !q_status_i.full;
  assign take           = sample_i.valid && sample_i.ready;

  // Sum of three squares stays below 2^32
  assign push_mag_o = sq_x_q + sq_y_q + sq_z_q;

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  // Squares, one multiplier per axis
  always_ff @(posedge clk_i) begin
    if (take) begin
      sq_x_q <= asp_pkg::MagW'(abs_x) * asp_pkg::MagW'(abs_x);
      sq_y_q <= asp_pkg::MagW'(abs_y) * asp_pkg::MagW'(abs_y);
      sq_z_q <= asp_pkg::MagW'(abs_z) * asp_pkg::MagW'(abs_z);
    end
  end

endmodule

@@ sv/asp_queue.sv @@
// ============================================================================
// asp_queue
// Small FIFO of magnitudes that decouples the front from the back.
// ============================================================================
module asp_queue #(
  parameter int unsigned Depth = asp_pkg::QueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [asp_pkg::MagW-1:0]  push_mag_i,
  input  logic                      pop_i,
  output logic [asp_pkg::MagW-1:0]  head_mag_o,
  output asp_pkg::q_status_t        status_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [asp_pkg::MagW-1:0] mem_q [Depth];
  logic [PtrW-1:0]          wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]          count_q;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign head_mag_o     = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_mag_i;
    end
  end

endmodule

@@ sv/asp_back.sv @@
// ============================================================================
// asp_back
// Holds the configuration and the detector state, classifies each magnitude
// against the previous one and registers the result for the output channel.
// ============================================================================
module asp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  asp_pkg::cfg_idx_t             cfg_idx_i,
  input  logic [asp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  asp_pkg::q_status_t            q_status_i,
  input  logic [asp_pkg::MagW-1:0]      head_mag_i,
  output logic                          pop_o,
  asp_result_if.source                  result_o
);

  // Configuration: window bounds kept already squared
  logic [asp_pkg::MagW-1:0]  lo_sq_q, hi_sq_q;
  logic [asp_pkg::RunW-1:0]  min_run_q;
  logic [asp_pkg::MagW-1:0]  cfg_sq;

  // Detector state
  logic [asp_pkg::MagW-1:0]  prev_q;
  asp_pkg::trend_e           trend_q, trend_d;
  logic [asp_pkg::RunW-1:0]  run_q, run_d;
  logic [asp_pkg::StepW-1:0] step_q, step_d;

  // Output register
  logic                      out_valid_q;
  asp_pkg::wave_e            event_q, event_d;
  logic [asp_pkg::StepW-1:0] out_step_q;
  logic [asp_pkg::MagW-1:0]  out_mag_q;

  logic                      active, rise, in_window, qualify;
  logic [asp_pkg::RunW-1:0]  run_before;

  assign cfg_sq = asp_pkg::MagW'(cfg_data_i[asp_pkg::BoundW-1:0]) *
                  asp_pkg::MagW'(cfg_data_i[asp_pkg::BoundW-1:0]);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_sq_q   <= asp_pkg::MagMinSqReset;
      hi_sq_q   <= asp_pkg::MagMaxSqReset;
      min_run_q <= asp_pkg::RiseRunReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        asp_pkg::CFG_MAG_MIN:  lo_sq_q   <= cfg_sq;
        asp_pkg::CFG_MAG_MAX:  hi_sq_q   <= cfg_sq;
        asp_pkg::CFG_RISE_RUN: min_run_q <= cfg_data_i[asp_pkg::RunW-1:0];
        default: ;
      endcase
    end
  end

  // Take the queue head when the output register is free or draining
  assign pop_o = !q_status_i.empty && (!out_valid_q || result_o.ready);

  // Classification of the head against the previous magnitude
  assign active     = (prev_q != '0);
  assign rise       = (head_mag_i >= prev_q);
  assign run_before = rise ? '0 : run_q;
  assign in_window  = (prev_q >= lo_sq_q) && (prev_q <= hi_sq_q);
  assign qualify    = (run_before >= min_run_q) || in_window;

  always_comb begin
    trend_d = trend_q;
    run_d   = run_q;
    step_d  = step_q;
    event_d = asp_pkg::WAVE_NONE;
    if (active) begin
      if (rise) begin
        trend_d = asp_pkg::TREND_RISE;
        if (run_q != asp_pkg::RunMax) begin
          run_d = run_q + 1'b1;
        end
        if (trend_q != asp_pkg::TREND_RISE) begin
          event_d = asp_pkg::WAVE_VALLEY;
        end
      end else begin
        trend_d = asp_pkg::TREND_FALL;
        run_d   = '0;
        // Change to falling counts as a step when qualified
        if (trend_q != asp_pkg::TREND_FALL && qualify) begin
          event_d = asp_pkg::WAVE_PEAK;
          if (step_q != asp_pkg::StepMax) begin
            step_d = step_q + 1'b1;
          end
        end
      end
    end
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      trend_q     <= asp_pkg::TREND_NONE;
      run_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        prev_q  <= head_mag_i;
        trend_q <= trend_d;
        run_q   <= run_d;
        step_q  <= step_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      event_q    <= event_d;
      out_step_q <= step_d;
      out_mag_q  <= head_mag_i;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.wave_event   = event_q;
  assign result_o.step_total   = out_step_q;
  assign result_o.magnitude_sq = out_mag_q;

endmodule

@@ sv/accel_step_peak_detector.sv @@
// ============================================================================
// accel_step_peak_detector
// Step counter on the squared magnitude of three-axis accelerometer samples:
// peaks after a run of rises or inside a window count as steps.
// ============================================================================
//  port       | dir | handshake     | transaction
//  -----------+-----+---------------+-----------------------------------------
//  sample_i   | in  | valid/ready   | accel_x, accel_y, accel_z (s16 each)
//  result_o   | out | valid/ready   | wave_event, step_total, magnitude_sq
//  cfg_*_i    | in  | write enable  | index 0 min, 1 max, 2 min rise run
//
// One sample per cycle sustained while the queue has room (square register,
// queue, output register). Squaring takes one 16x16 multiplier per axis.
// Reset restores the register defaults and clears the detector state.
// Front and back stall independently through a queue of QDepth entries.
// ============================================================================
module accel_step_peak_detector #(
  parameter int unsigned QDepth = asp_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  asp_sample_if.sink                    sample_i,
  asp_result_if.source                  result_o,
  input  logic                          cfg_we_i,
  input  asp_pkg::cfg_idx_t             cfg_idx_i,
  input  logic [asp_pkg::CfgDataW-1:0]  cfg_data_i
);

  asp_pkg::q_status_t        q_status;
  logic                      push, pop;
  logic [asp_pkg::MagW-1:0]  push_mag, head_mag;

  // Squaring front
  asp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_i),
    .q_status_i (q_status),
    .push_o     (push),
    .push_mag_o (push_mag)
  );

  // Decoupling queue
  asp_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_mag_i (push_mag),
    .pop_i      (pop),
    .head_mag_o (head_mag),
    .status_o   (q_status)
  );

  // Detection back end
  asp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_status_i (q_status),
    .head_mag_i (head_mag),
    .pop_o      (pop),
    .result_o   (result_o)
  );

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for accel_step_peak_detector. Samples go in through a
// bursty valid/ready source while the result side stalls on its own pattern.
// A local step-detector model predicts every result, and the checker compares
// each result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait  = 6;
  localparam int unsigned TrafficPhaseLen = 80;
  // Index with no register behind it; writes to it must be ignored
  localparam asp_pkg::cfg_idx_t CFG_UNUSED = 2'd3;

  typedef struct packed {
    asp_pkg::wave_e                 wave;
    logic [asp_pkg::StepW-1:0]      steps;
    logic [asp_pkg::MagW-1:0]       mag;
  } detection_t;

  // Clock and DUT-facing signals
  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  asp_pkg::cfg_idx_t            cfg_idx_i;
  logic [asp_pkg::CfgDataW-1:0] cfg_data_i;

  asp_sample_if sample_if ();
  asp_result_if result_if ();

  accel_step_peak_detector dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Detector model: settings and state
  logic [asp_pkg::BoundW-1:0] win_min    = asp_pkg::MagMinReset;
  logic [asp_pkg::BoundW-1:0] win_max    = asp_pkg::MagMaxReset;
  logic [asp_pkg::RunW-1:0]   rise_min   = asp_pkg::RiseRunReset;
  logic [asp_pkg::MagW-1:0]   prev_mag   = '0;
  asp_pkg::trend_e            cur_trend  = asp_pkg::TREND_NONE;
  logic [asp_pkg::RunW-1:0]   rise_run   = '0;
  logic [asp_pkg::StepW-1:0]  step_count = '0;

  detection_t  detections_due[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Traffic shaping
  int unsigned burst_left = 0;
  int unsigned stall_phase_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_tick = 0;

  // Random walk of the magnitude trace
  int trace_level = 10;
  int trace_step_left = 0;
  bit trace_up = 1'b1;

  function automatic logic [asp_pkg::MagW-1:0] axis_square(
      input logic signed [asp_pkg::AccelW-1:0] v);
    logic [asp_pkg::AccelW-1:0] a;
    a = v[asp_pkg::AccelW-1] ? asp_pkg::AccelW'(-v) : v;
    return asp_pkg::MagW'(a) * asp_pkg::MagW'(a);
  endfunction

  // Advance the model by one sample and return the result it must produce
  function automatic detection_t detect_step(input logic signed [asp_pkg::AccelW-1:0] x,
                                             input logic signed [asp_pkg::AccelW-1:0] y,
                                             input logic signed [asp_pkg::AccelW-1:0] z);
    logic [asp_pkg::MagW-1:0] mag;
    logic [asp_pkg::MagW-1:0] lo;
    logic [asp_pkg::MagW-1:0] hi;
    logic [asp_pkg::RunW-1:0] run_before;
    asp_pkg::trend_e          next_trend;
    detection_t               res;
    mag = axis_square(x) + axis_square(y) + axis_square(z);
    res.wave = asp_pkg::WAVE_NONE;
    // no detection while the previous magnitude is zero
    if (prev_mag != '0) begin
      run_before = '0;
      if (mag >= prev_mag) begin
        next_trend = asp_pkg::TREND_RISE;
        if (rise_run != asp_pkg::RunMax) rise_run = rise_run + 1'b1;
      end else begin
        next_trend = asp_pkg::TREND_FALL;
        run_before = rise_run;
        rise_run   = '0;
      end
      if (next_trend != cur_trend) begin
        if (next_trend == asp_pkg::TREND_FALL) begin
          lo = asp_pkg::MagW'(win_min) * asp_pkg::MagW'(win_min);
          hi = asp_pkg::MagW'(win_max) * asp_pkg::MagW'(win_max);
          if (run_before >= rise_min || (prev_mag >= lo && prev_mag <= hi)) begin
            res.wave = asp_pkg::WAVE_PEAK;
            if (step_count != asp_pkg::StepMax) step_count = step_count + 1'b1;
          end
        end else begin
          res.wave = asp_pkg::WAVE_VALLEY;
        end
      end
      cur_trend = next_trend;
    end
    prev_mag  = mag;
    res.steps = step_count;
    res.mag   = mag;
    return res;
  endfunction

  // Drive one sample transaction; bursts of random length with random gaps
  task automatic send_sample(input logic signed [asp_pkg::AccelW-1:0] x,
                             input logic signed [asp_pkg::AccelW-1:0] y,
                             input logic signed [asp_pkg::AccelW-1:0] z);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
      sample_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    if (burst_left != 0) burst_left--;
    sample_if.valid   <= 1'b1;
    sample_if.accel_x <= x;
    sample_if.accel_y <= y;
    sample_if.accel_z <= z;
    do @(posedge clk_i); while (sample_if.ready !== 1'b1);
    detections_due.push_back(detect_step(x, y, z));
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_drained();
    @(negedge clk_i);
    sample_if.valid <= 1'b0;
    while (detections_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_register(input asp_pkg::cfg_idx_t idx,
                                input logic [asp_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      asp_pkg::CFG_MAG_MIN:  win_min  = data;
      asp_pkg::CFG_MAG_MAX:  win_max  = data;
      asp_pkg::CFG_RISE_RUN: rise_min = data[asp_pkg::RunW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_detector(input logic [asp_pkg::BoundW-1:0] lo,
                              input logic [asp_pkg::BoundW-1:0] hi,
                              input logic [asp_pkg::CfgDataW-1:0] run);
    write_register(asp_pkg::CFG_MAG_MIN, lo);
    write_register(asp_pkg::CFG_MAG_MAX, hi);
    write_register(asp_pkg::CFG_RISE_RUN, run);
  endtask

  // Next sample of a rising/falling trace with random run lengths and sizes
  task automatic next_trace_sample(output logic signed [asp_pkg::AccelW-1:0] x,
                                   output logic signed [asp_pkg::AccelW-1:0] y,
                                   output logic signed [asp_pkg::AccelW-1:0] z);
    int lvl;
    if (trace_step_left == 0) begin
      trace_up = !trace_up;
      trace_step_left = $urandom_range(1, 7);
    end
    trace_step_left--;
    lvl = trace_level + (trace_up ? 1 : -1) * int'($urandom_range(0, 8));
    if (lvl < 0) begin
      lvl = 0;
      trace_up = 1'b1;
    end else if (lvl > 90) begin
      lvl = 90;
      trace_up = 1'b0;
    end
    trace_level = lvl;
    x = $urandom_range(0, 1) ? asp_pkg::AccelW'(-lvl) : asp_pkg::AccelW'(lvl);
    y = $urandom_range(0, 1) ? asp_pkg::AccelW'(-(lvl / 2)) : asp_pkg::AccelW'(lvl / 2);
    z = asp_pkg::AccelW'(int'($urandom_range(0, 2)) - 1);
  endtask

  // Result checker: compare each accepted transaction with the oldest prediction
  always @(posedge clk_i) begin
    detection_t due;
    if (rst_ni && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (detections_due.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected result: wave %0d steps %0d mag %0d", $realtime,
                   result_if.wave_event, result_if.step_total, result_if.magnitude_sq);
        mismatches++;
      end else begin
        due = detections_due.pop_front();
        if (result_if.wave_event !== due.wave || result_if.step_total !== due.steps ||
            result_if.magnitude_sq !== due.mag) begin
          if (mismatches < 10)
            $display("[%0t] mismatch: wave %0d/%0d steps %0d/%0d mag %0d/%0d (exp/act)",
                     $realtime, due.wave, result_if.wave_event, due.steps,
                     result_if.step_total, due.mag, result_if.magnitude_sq);
          mismatches++;
        end
      end
    end
  end

  // Result-side stalls: phases of open, random, periodic and long-blocked ready
  always @(negedge clk_i) begin
    if (stall_phase_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_phase_left = $urandom_range(8, 64);
      stall_tick = 0;
    end
    stall_phase_left--;
    stall_tick++;
    case (stall_mode)
      0: result_if.ready <= 1'b1;
      1: result_if.ready <= $urandom_range(0, 1);
      2: result_if.ready <= (stall_tick % 3) != 0;
      default: result_if.ready <= stall_tick > 20;
    endcase
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // Defaults after reset: first sample, zero magnitudes, fall with no rises,
  // peaks by rise run and by window, valleys, field extremes, equal magnitudes
  task automatic test_reset_defaults();
    send_sample(0, 0, 0);
    send_sample(10, 0, 0);
    send_sample(5, 0, 0);
    send_sample(30, 0, 0);
    send_sample(40, 0, 0);
    send_sample(45, 0, 0);
    send_sample(1, 0, 0);
    send_sample(30, 0, 0);
    send_sample(2, 0, 0);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, -1, 0);
    send_sample(-32768, -32768, -32768);
    send_sample(-32768, -32768, -32768);
    send_sample(0, 0, 0);
    send_sample(-1, -1, -1);
    send_sample(0, 0, 1);
    wait_drained();
  endtask

  // Every register, the unused index, reversed and full windows, zero rise run
  task automatic test_register_writes();
    write_register(CFG_UNUSED, 16'hFFFF);
    set_detector(16'hFFFF, 16'h0000, 16'hFF00);
    send_sample(3, 0, 0);
    send_sample(2, 0, 0);
    send_sample(4, 0, 0);
    send_sample(1, 0, 0);
    wait_drained();
    set_detector(16'h0000, 16'hFFFF, 16'h00FF);
    send_sample(6, 0, 0);
    send_sample(7, 0, 0);
    send_sample(5, 0, 0);
    send_sample(-7, 3, -2);
    wait_drained();
  endtask

  // Rise run saturates: a long climb qualifies a peak at the largest run setting,
  // a shorter one does not
  task automatic test_rise_saturation();
    set_detector(16'hFFFF, 16'h0000, 16'h00FF);
    for (int i = 1; i <= 300; i++) send_sample(asp_pkg::AccelW'(i), 0, 0);
    send_sample(0, 0, 1);
    for (int i = 1; i <= 100; i++) send_sample(0, asp_pkg::AccelW'(-i), 0);
    send_sample(0, 1, 0);
    wait_drained();
  endtask

  task automatic run_traffic_phase(input logic [asp_pkg::BoundW-1:0] lo,
                                   input logic [asp_pkg::BoundW-1:0] hi,
                                   input logic [asp_pkg::CfgDataW-1:0] run);
    logic signed [asp_pkg::AccelW-1:0] x;
    logic signed [asp_pkg::AccelW-1:0] y;
    logic signed [asp_pkg::AccelW-1:0] z;
    int unsigned pick;
    set_detector(lo, hi, run);
    for (int n = 0; n < TrafficPhaseLen; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        next_trace_sample(x, y, z);
      end else if (pick < 79) begin
        x = '0;
        y = '0;
        z = '0;
      end else if (pick < 87) begin
        x = asp_pkg::AccelW'(int'($urandom_range(0, 2000)) - 1000);
        y = asp_pkg::AccelW'(int'($urandom_range(0, 2000)) - 1000);
        z = asp_pkg::AccelW'(int'($urandom_range(0, 2000)) - 1000);
      end else begin
        x = asp_pkg::AccelW'($urandom);
        y = asp_pkg::AccelW'($urandom);
        z = asp_pkg::AccelW'($urandom);
      end
      send_sample(x, y, z);
    end
    wait_drained();
  endtask

  // Random traces under several detector settings, extremes among them
  task automatic test_random_traffic();
    run_traffic_phase(asp_pkg::MagMinReset, asp_pkg::MagMaxReset,
                      16'(asp_pkg::RiseRunReset));
    run_traffic_phase(16'h0000, 16'hFFFF, 16'h0000);
    run_traffic_phase(16'hFFFF, 16'h0000, 16'h00FF);
    run_traffic_phase(asp_pkg::BoundW'($urandom_range(0, 100)),
                      asp_pkg::BoundW'($urandom_range(0, 120)),
                      asp_pkg::CfgDataW'({$urandom_range(0, 255),
                                          8'($urandom_range(0, 6))}));
    run_traffic_phase(asp_pkg::BoundW'($urandom_range(0, 60)),
                      asp_pkg::BoundW'($urandom_range(40, 120)),
                      asp_pkg::CfgDataW'({$urandom_range(0, 255),
                                          8'($urandom_range(0, 4))}));
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = asp_pkg::CFG_MAG_MIN;
    cfg_data_i        = '0;
    sample_if.valid   = 1'b0;
    sample_if.accel_x = '0;
    sample_if.accel_y = '0;
    sample_if.accel_z = '0;
    result_if.ready   = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_reset_defaults();
    test_register_writes();
    test_rise_saturation();
    test_random_traffic();

    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
